FILE: rtl/lss_pkg.sv
`default_nettype none
package lss_pkg;

  localparam int WORD_BITS  = 32;
  localparam int MINOR_BITS = 2 * WORD_BITS + 1;
  localparam int PROD_BITS  = WORD_BITS + MINOR_BITS;
  localparam int DET_BITS   = 3 * WORD_BITS + 3;
  localparam int DET_STAGES = 5;
  localparam int DIV_STAGES = WORD_BITS + 3;
  localparam int LATENCY    = DET_STAGES + DIV_STAGES + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [DET_BITS-1:0]  det_t;

  typedef struct packed {
    word_t coef_a;
    word_t coef_b;
    word_t coef_c;
    word_t rhs_one;
    word_t coef_e;
    word_t coef_f;
    word_t coef_g;
    word_t rhs_two;
    word_t coef_i;
    word_t coef_j;
    word_t coef_k;
    word_t rhs_three;
  } in_item_t;

  typedef struct packed {
    word_t sol_x;
    word_t sol_y;
    word_t sol_z;
    logic  singular;
    logic  saturated;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/linear_system_3x3_solver.sv
// 3x3 linear system solver, Cramer's rule in signed fixed point.
// Input channel: drive in_item with the twelve coefficients and pulse start;
// the request is taken at any edge where start is high and busy is low.
// busy stays low: one system can be taken every clock cycle.
// Result channel: out_valid is high for exactly one cycle with out_item;
// the receiver cannot stall, so results leave in request order.
// Pipeline from request to result: lss_det forms the determinant and three
//   numerators (each minor split into a low unsigned word and a high signed
//   part for the partial products), the pipelined restoring divider runs
//   (one quotient bit per stage, three dividers side by side), and a final
//   register merges the singular and saturation flags.
// Throughput: one system per cycle, fixed.
// A zero determinant gives zero solutions with singular set.
// Reset (synchronous, active low) drops every request in flight.
`default_nettype none
module linear_system_3x3_solver #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lss_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output lss_pkg::out_item_t      out_item
);

  logic          det_vld;
  lss_pkg::det_t det, num_x, num_y, num_z;
  logic          vx, vy, vz;
  lss_pkg::word_t qx, qy, qz;
  logic          cx, cy, cz;
  logic          zx, zy, zz;

  logic               out_valid_r;
  lss_pkg::out_item_t out_item_r;

  assign busy = 1'b0;

  lss_det u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_item),
    .out_valid(det_vld),
    .det      (det),
    .num_x    (num_x),
    .num_y    (num_y),
    .num_z    (num_z)
  );

  lss_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .rst_n(rst_n), .in_valid(det_vld), .num(num_x), .den(det),
    .out_valid(vx), .quot(qx), .clip(cx), .den_zero(zx)
  );

  lss_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .rst_n(rst_n), .in_valid(det_vld), .num(num_y), .den(det),
    .out_valid(vy), .quot(qy), .clip(cy), .den_zero(zy)
  );

  lss_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk(clk), .rst_n(rst_n), .in_valid(det_vld), .num(num_z), .den(det),
    .out_valid(vz), .quot(qz), .clip(cz), .den_zero(zz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vx & vy & vz;
    end
  end

  // zero determinant overrides whatever the dividers produced
  always_ff @(posedge clk) begin
    if (zx | zy | zz) begin
      out_item_r.sol_x     <= '0;
      out_item_r.sol_y     <= '0;
      out_item_r.sol_z     <= '0;
      out_item_r.singular  <= 1'b1;
      out_item_r.saturated <= 1'b0;
    end else begin
      out_item_r.sol_x     <= qx;
      out_item_r.sol_y     <= qy;
      out_item_r.sol_z     <= qz;
      out_item_r.singular  <= 1'b0;
      out_item_r.saturated <= cx | cy | cz;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

FILE: rtl/lss_det.sv
`default_nettype none
module lss_det (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire lss_pkg::in_item_t in_item,
  output logic                  out_valid,
  output lss_pkg::det_t         det,
  output lss_pkg::det_t         num_x,
  output lss_pkg::det_t         num_y,
  output lss_pkg::det_t         num_z
);

  localparam int W  = lss_pkg::WORD_BITS;
  localparam int MB = lss_pkg::MINOR_BITS;
  localparam int PB = lss_pkg::PROD_BITS;
  localparam int DB = lss_pkg::DET_BITS;
  localparam int NT = 12;

  logic [lss_pkg::DET_STAGES-1:0] vld_r;

  logic signed [2*W-1:0] pr_r [NT];
  lss_pkg::word_t a1_r, b1_r, c1_r, d1_r;
  logic signed [MB-1:0]  m_r [6];
  lss_pkg::word_t a2_r, b2_r, c2_r, d2_r;
  lss_pkg::word_t        s3_w [NT];
  logic signed [MB-1:0]  s3_m [NT];
  logic signed [2*W:0]   lo_r [NT];
  logic signed [2*W:0]   hi_r [NT];
  logic signed [PB-1:0]  prod_r [NT];
  lss_pkg::det_t det_r, nx_r, ny_r, nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[lss_pkg::DET_STAGES-2:0], in_valid};
    end
  end

  // 2x2 minors of equations two and three, as product pairs
  always_ff @(posedge clk) begin
    pr_r[0]  <= $signed(in_item.coef_f) * $signed(in_item.coef_k);
    pr_r[1]  <= $signed(in_item.coef_g) * $signed(in_item.coef_j);
    pr_r[2]  <= $signed(in_item.coef_e) * $signed(in_item.coef_k);
    pr_r[3]  <= $signed(in_item.coef_g) * $signed(in_item.coef_i);
    pr_r[4]  <= $signed(in_item.coef_e) * $signed(in_item.coef_j);
    pr_r[5]  <= $signed(in_item.coef_f) * $signed(in_item.coef_i);
    pr_r[6]  <= $signed(in_item.rhs_two) * $signed(in_item.coef_k);
    pr_r[7]  <= $signed(in_item.coef_g) * $signed(in_item.rhs_three);
    pr_r[8]  <= $signed(in_item.rhs_two) * $signed(in_item.coef_j);
    pr_r[9]  <= $signed(in_item.coef_f) * $signed(in_item.rhs_three);
    pr_r[10] <= $signed(in_item.coef_e) * $signed(in_item.rhs_three);
    pr_r[11] <= $signed(in_item.rhs_two) * $signed(in_item.coef_i);
    a1_r <= in_item.coef_a;
    b1_r <= in_item.coef_b;
    c1_r <= in_item.coef_c;
    d1_r <= in_item.rhs_one;
  end

  // minor order: fg, eg, ef, hg, hf, eh
  always_ff @(posedge clk) begin
    for (int n = 0; n < 6; n++) begin
      m_r[n] <= MB'(pr_r[2*n]) - MB'(pr_r[2*n+1]);
    end
    a2_r <= a1_r;
    b2_r <= b1_r;
    c2_r <= c1_r;
    d2_r <= d1_r;
  end

  always_comb begin
    s3_w[0]  = a2_r; s3_m[0]  = m_r[0];
    s3_w[1]  = b2_r; s3_m[1]  = m_r[1];
    s3_w[2]  = c2_r; s3_m[2]  = m_r[2];
    s3_w[3]  = d2_r; s3_m[3]  = m_r[0];
    s3_w[4]  = b2_r; s3_m[4]  = m_r[3];
    s3_w[5]  = c2_r; s3_m[5]  = m_r[4];
    s3_w[6]  = a2_r; s3_m[6]  = m_r[3];
    s3_w[7]  = d2_r; s3_m[7]  = m_r[1];
    s3_w[8]  = c2_r; s3_m[8]  = m_r[5];
    s3_w[9]  = d2_r; s3_m[9]  = m_r[2];
    s3_w[10] = a2_r; s3_m[10] = m_r[4];
    s3_w[11] = b2_r; s3_m[11] = m_r[5];
  end

  // split each minor into a low unsigned word and a high signed part
  always_ff @(posedge clk) begin
    for (int n = 0; n < NT; n++) begin
      lo_r[n] <= $signed(s3_w[n]) * $signed({1'b0, s3_m[n][W-1:0]});
      hi_r[n] <= $signed(s3_w[n]) * $signed(s3_m[n][MB-1:W]);
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < NT; n++) begin
      prod_r[n] <= (PB'(hi_r[n]) <<< W) + PB'(lo_r[n]);
    end
  end

  always_ff @(posedge clk) begin
    det_r <= DB'(prod_r[0]) - DB'(prod_r[1])  + DB'(prod_r[2]);
    nx_r  <= DB'(prod_r[3]) - DB'(prod_r[4])  + DB'(prod_r[5]);
    ny_r  <= DB'(prod_r[6]) - DB'(prod_r[7])  + DB'(prod_r[8]);
    nz_r  <= DB'(prod_r[9]) - DB'(prod_r[10]) - DB'(prod_r[11]);
  end

  assign out_valid = vld_r[lss_pkg::DET_STAGES-1];
  assign det       = det_r;
  assign num_x     = nx_r;
  assign num_y     = ny_r;
  assign num_z     = nz_r;

endmodule
`default_nettype wire

FILE: rtl/lss_div.sv
`default_nettype none
module lss_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire lss_pkg::det_t  num,
  input  wire lss_pkg::det_t  den,
  output logic                out_valid,
  output lss_pkg::word_t      quot,
  output logic                clip,
  output logic                den_zero
);

  localparam int W   = lss_pkg::WORD_BITS;
  localparam int DB  = lss_pkg::DET_BITS;
  localparam int NSB = DB + FRAC_BITS;
  localparam int CB  = DB + W;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  logic          a_vld_r, a_neg_r, a_zero_r;
  logic [DB-1:0] a_nm_r, a_dm_r;
  logic [NSB-1:0] ns;

  logic          vld_r  [W+1];
  logic          neg_r  [W+1];
  logic          zero_r [W+1];
  logic          ovf_r  [W+1];
  logic [DB-1:0] rem_r  [W+1];
  logic [DB-1:0] dm_r   [W+1];
  logic [W-1:0]  q_r    [W+1];
  logic [W-1:0]  lo_r   [W+1];
  logic [DB:0]   trial  [W];
  logic          ge     [W];

  logic          f_vld_r, f_clip_r, f_zero_r;
  logic [W-1:0]  f_q_r;
  logic          sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      for (int n = 0; n <= W; n++) begin
        vld_r[n] <= 1'b0;
      end
    end else begin
      a_vld_r  <= in_valid;
      vld_r[0] <= a_vld_r;
      for (int n = 0; n < W; n++) begin
        vld_r[n+1] <= vld_r[n];
      end
      f_vld_r <= vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    a_neg_r  <= num[DB-1] ^ den[DB-1];
    a_zero_r <= (den == '0);
    a_nm_r   <= num[DB-1] ? DB'(~num) + DB'(1) : DB'(num);
    a_dm_r   <= den[DB-1] ? DB'(~den) + DB'(1) : DB'(den);
  end

  assign ns = NSB'(a_nm_r) << FRAC_BITS;

  // quotient at or above 2^W saturates; otherwise W restoring steps suffice
  always_ff @(posedge clk) begin
    ovf_r[0]  <= CB'(ns) >= (CB'(a_dm_r) << W);
    rem_r[0]  <= DB'(ns >> W);
    lo_r[0]   <= ns[W-1:0];
    dm_r[0]   <= a_dm_r;
    q_r[0]    <= '0;
    neg_r[0]  <= a_neg_r;
    zero_r[0] <= a_zero_r;
  end

  always_comb begin
    for (int n = 0; n < W; n++) begin
      trial[n] = {rem_r[n], lo_r[n][W-1]};
      ge[n]    = trial[n] >= {1'b0, dm_r[n]};
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < W; n++) begin
      rem_r[n+1]  <= ge[n] ? DB'(trial[n] - {1'b0, dm_r[n]}) : DB'(trial[n]);
      q_r[n+1]    <= {q_r[n][W-2:0], ge[n]};
      lo_r[n+1]   <= lo_r[n] << 1;
      dm_r[n+1]   <= dm_r[n];
      ovf_r[n+1]  <= ovf_r[n];
      neg_r[n+1]  <= neg_r[n];
      zero_r[n+1] <= zero_r[n];
    end
  end

  assign sat = ovf_r[W] | (neg_r[W] ? (q_r[W] > HALF) : q_r[W][W-1]);

  always_ff @(posedge clk) begin
    f_clip_r <= sat;
    f_zero_r <= zero_r[W];
    if (sat) begin
      f_q_r <= neg_r[W] ? HALF : ~HALF;
    end else begin
      f_q_r <= neg_r[W] ? (~q_r[W] + W'(1)) : q_r[W];
    end
  end

  assign out_valid = f_vld_r;
  assign quot      = $signed(f_q_r);
  assign clip      = f_clip_r;
  assign den_zero  = f_zero_r;

endmodule
`default_nettype wire

FILE: rtl/lss_checker.sv
`default_nettype none
module lss_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire lss_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire lss_pkg::out_item_t out_item
);

  localparam int LAT = lss_pkg::LATENCY;
  localparam lss_pkg::word_t WMAX = {1'b0, {(lss_pkg::WORD_BITS-1){1'b1}}};
  localparam lss_pkg::word_t WMIN = {1'b1, {(lss_pkg::WORD_BITS-1){1'b0}}};

  logic in_seen;
  assign in_seen = (in_item == in_item) || 1'b1;

  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_seen) |-> ##LAT out_valid)
    else $error("request produced no result");

  a_result_had_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without request");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.singular) |->
      (out_item.sol_x == '0 && out_item.sol_y == '0 && out_item.sol_z == '0
       && !out_item.saturated))
    else $error("singular result not cleared");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.saturated) |->
      (out_item.sol_x == WMAX || out_item.sol_x == WMIN ||
       out_item.sol_y == WMAX || out_item.sol_y == WMIN ||
       out_item.sol_z == WMAX || out_item.sol_z == WMIN))
    else $error("saturated flag without a clipped solution");

endmodule

bind linear_system_3x3_solver lss_checker u_lss_checker (.*);
`default_nettype wire
